// ----- hdl/lfu_page_replacer_core_assert.svh -----
// assertion macros for the lfu page replacer checker
// needs clk and rst in the scope where the macros are used
`ifndef LFU_PAGE_REPLACER_CORE_ASSERT_SVH
`define LFU_PAGE_REPLACER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LFU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LFU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/lfu_pkg.sv -----
// shared types and constants for the lfu page replacer
// no dependencies
package lfu_pkg;

  localparam int FRAMES     = 16;
  localparam int PAGE_BITS  = 16;
  localparam int COUNT_BITS = 16;

  // transaction field widths
  localparam int PAGE_NUM_BITS  = 16;
  localparam int FRAME_IDX_BITS = 4;
  localparam int FAULT_BITS     = 32;

  // configuration port
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;
  localparam int FIU_BITS   = 5;
  localparam logic [FIU_BITS-1:0] FIU_RESET = 5'd16;
  localparam logic [PADDR_BITS-3:0] REG_FRAMES_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WB
  } state_t;

endpackage

// ----- hdl/lfu_if.sv -----
// valid/ready channel interfaces for page references and results
// depends on lfu_pkg
interface lfu_in_if;
  logic                               valid;
  logic                               ready;
  logic [lfu_pkg::PAGE_NUM_BITS-1:0]  page_ref;
  logic                               end_of_string;

  modport source (output valid, page_ref, end_of_string, input ready);
  modport sink   (input valid, page_ref, end_of_string, output ready);
endinterface

interface lfu_out_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic [lfu_pkg::FRAME_IDX_BITS-1:0]  frame_index;
  logic [lfu_pkg::FAULT_BITS-1:0]      fault_total;
  logic                                string_done;

  modport source (output valid, hit, frame_index, fault_total, string_done, input ready);
  modport sink   (input valid, hit, frame_index, fault_total, string_done, output ready);
endinterface

// ----- hdl/lfu_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module lfu_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/lfu_page_replacer_core.sv -----
// top level of the lfu page replacer: frame ram, scan sequencer, apb register
// depends on lfu_pkg, lfu_if (lfu_in_if, lfu_out_if) and lfu_ram
//
//   channel   dir   handshake            payload
//   in_ch     in    valid/ready          page_ref, end_of_string
//   out_ch    out   valid/ready          hit, frame_index, fault_total, string_done
//   apb       in    psel/penable/pready  paddr, pwdata, prdata (frames_in_use)
//
// an item passes through an accept in ST_IDLE, one frame ram read per active frame in
// ST_SCAN (active being frames_in_use held to 1..FRAMES) and a write-back in ST_WB;
// the single ram read port makes the scan serial, and no new item is taken before the write-back.
// rst clears the valid bits, fault total and control directly; no clearing pass.
// the write-back waits while a previous result is still held in the output register.
module lfu_page_replacer_core #(
  parameter int FRAMES     = lfu_pkg::FRAMES,
  parameter int PAGE_BITS  = lfu_pkg::PAGE_BITS,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  lfu_in_if.sink                           in_ch,
  lfu_out_if.source                        out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lfu_pkg::PADDR_BITS-1:0]   paddr,
  input  logic [lfu_pkg::PDATA_BITS-1:0]   pwdata,
  output logic [lfu_pkg::PDATA_BITS-1:0]   prdata,
  output logic                             pready
);

  localparam int IW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW   = ($clog2(FRAMES + 1) > lfu_pkg::FIU_BITS) ?
                        $clog2(FRAMES + 1) : lfu_pkg::FIU_BITS;
  localparam int RAMW = PAGE_BITS + COUNT_BITS;

  lfu_pkg::state_t state, state_next;

  logic [lfu_pkg::FIU_BITS-1:0]   frames_in_use;
  logic [FRAMES-1:0]              frame_valid;
  logic [lfu_pkg::FAULT_BITS-1:0] fault_counter;

  // current item
  logic [PAGE_BITS-1:0]  item_page;
  logic                  item_last;
  logic [IW-1:0]         scan_idx;
  logic                  found;
  logic [IW-1:0]         slot;
  logic [COUNT_BITS-1:0] least;
  logic [COUNT_BITS-1:0] hit_count;

  // output register
  logic                              out_valid;
  logic                              out_hit;
  logic [lfu_pkg::FRAME_IDX_BITS-1:0] out_frame;
  logic [lfu_pkg::FAULT_BITS-1:0]    out_fault;
  logic                              out_done;

  // sequencer outputs
  logic          accept;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wb_go;

  // ram
  logic [RAMW-1:0]       rd_data;
  logic [RAMW-1:0]       wr_data;
  logic [COUNT_BITS-1:0] ent_count;
  logic [PAGE_BITS-1:0]  ent_page;
  logic                  ent_valid;
  logic                  ent_match;
  logic [COUNT_BITS-1:0] ent_eff;

  logic [CW-1:0] fiu_ext;
  logic [CW-1:0] active;
  logic [IW-1:0] last_idx;
  logic [IW-1:0] next_idx;

  logic [COUNT_BITS-1:0]          new_count;
  logic [lfu_pkg::FAULT_BITS-1:0] fault_next;
  logic                           cfg_write;

  // apb register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[lfu_pkg::PADDR_BITS-1:2] == lfu_pkg::REG_FRAMES_IN_USE);
  assign prdata    = (paddr[lfu_pkg::PADDR_BITS-1:2] == lfu_pkg::REG_FRAMES_IN_USE) ?
                     lfu_pkg::PDATA_BITS'(frames_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lfu_pkg::FIU_RESET;
    end else if (cfg_write) begin
      frames_in_use <= pwdata[lfu_pkg::FIU_BITS-1:0];
    end
  end

  // zero acts as one, above FRAMES acts as FRAMES
  always_comb begin
    fiu_ext = CW'(frames_in_use);
    if (fiu_ext == '0) begin
      active = CW'(1);
    end else if (fiu_ext > CW'(FRAMES)) begin
      active = CW'(FRAMES);
    end else begin
      active = fiu_ext;
    end
    last_idx = IW'(active - CW'(1));
  end

  assign next_idx = scan_idx + IW'(1);

  // frame entry under inspection, read in the cycle before
  assign ent_count = rd_data[COUNT_BITS-1:0];
  assign ent_page  = rd_data[COUNT_BITS +: PAGE_BITS];
  assign ent_valid = frame_valid[scan_idx];
  assign ent_match = ent_valid && (ent_page == item_page);
  assign ent_eff   = ent_valid ? ent_count : '0;

  lfu_ram #(
    .WIDTH (RAMW),
    .DEPTH (FRAMES)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (wb_go),
    .wr_addr (slot),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // write-back values
  always_comb begin
    if (found) begin
      new_count = (hit_count != '1) ? hit_count + COUNT_BITS'(1) : hit_count;
    end else begin
      new_count = COUNT_BITS'(1);
    end
    wr_data = {item_page, new_count};
    if (!found && (fault_counter != '1)) begin
      fault_next = fault_counter + lfu_pkg::FAULT_BITS'(1);
    end else begin
      fault_next = fault_counter;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    accept      = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wb_go       = 1'b0;
    unique case (state)
      lfu_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          accept     = 1'b1;
          rd_en      = 1'b1;
          state_next = lfu_pkg::ST_SCAN;
        end
      end
      lfu_pkg::ST_SCAN: begin
        if (scan_idx == last_idx) begin
          state_next = lfu_pkg::ST_WB;
        end else begin
          rd_en   = 1'b1;
          rd_addr = next_idx;
        end
      end
      lfu_pkg::ST_WB: begin
        if (!out_valid || out_ch.ready) begin
          wb_go      = 1'b1;
          state_next = lfu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      item_page <= PAGE_BITS'(in_ch.page_ref);
      item_last <= in_ch.end_of_string;
      scan_idx  <= '0;
      found     <= 1'b0;
    end else if (state == lfu_pkg::ST_SCAN) begin
      scan_idx <= next_idx;
      if (!found && ent_match) begin
        found     <= 1'b1;
        hit_count <= ent_count;
      end
      // slot freezes once a match is seen
      if (!found && (ent_match || scan_idx == '0 || ent_eff < least)) begin
        slot <= scan_idx;
      end
      if (scan_idx == '0 || ent_eff < least) begin
        least <= ent_eff;
      end
    end
  end

  // frame state and fault total
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid   <= '0;
      fault_counter <= '0;
    end else if (wb_go) begin
      if (item_last) begin
        frame_valid   <= '0;
        fault_counter <= '0;
      end else begin
        frame_valid[slot] <= 1'b1;
        fault_counter     <= fault_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wb_go) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_go) begin
      out_hit   <= found;
      out_frame <= lfu_pkg::FRAME_IDX_BITS'(slot);
      out_fault <= fault_next;
      out_done  <= item_last;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.hit         = out_hit;
  assign out_ch.frame_index = out_frame;
  assign out_ch.fault_total = out_fault;
  assign out_ch.string_done = out_done;

endmodule

// ----- hdl/lfu_chk.sv -----
// port-level checker for lfu_page_replacer_core and its bind
// depends on lfu_pkg and lfu_page_replacer_core_assert.svh
`include "lfu_page_replacer_core_assert.svh"

module lfu_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             hit,
  input logic [lfu_pkg::FAULT_BITS-1:0]   fault_total
);

  // one item in flight: input closes right after a transaction
  `LFU_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input taken while busy")

  // a fault result always counts at least this fault
  `LFU_ASSERT_SAME(a_fault_counted, out_valid && !hit, fault_total != '0, "fault not counted")

  `LFU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

  `LFU_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(fault_total) && $stable(hit),
                   "stalled result changed")

endmodule

bind lfu_page_replacer_core lfu_chk u_lfu_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .hit         (out_ch.hit),
  .fault_total (out_ch.fault_total)
);

// ----- bench/lfu_page_replacer_checker.sv -----
// scoreboard for the lfu page replacer: tracks the frame table and the fault total
// from the accepted page references and register writes, and compares every result
// depends on lfu_pkg and lfu_if (lfu_in_if, lfu_out_if)
module lfu_page_replacer_checker (
  input  logic                           clk,
  input  logic                           rst,
  lfu_in_if                              in_mon,
  lfu_out_if                             out_mon,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [lfu_pkg::PADDR_BITS-1:0] paddr,
  input  logic [lfu_pkg::PDATA_BITS-1:0] pwdata,
  input  logic [lfu_pkg::PDATA_BITS-1:0] prdata,
  output int                             errors,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [lfu_pkg::PADDR_BITS-1:0] FIU_ADDR = {lfu_pkg::REG_FRAMES_IN_USE, 2'b00};

  typedef struct packed {
    logic                               hit;
    logic [lfu_pkg::FRAME_IDX_BITS-1:0] frame_index;
    logic [lfu_pkg::FAULT_BITS-1:0]     fault_total;
    logic                               string_done;
  } lookup_result_t;

  // shadow of the frame table
  logic                           held_valid [lfu_pkg::FRAMES];
  logic [lfu_pkg::PAGE_BITS-1:0]  held_page  [lfu_pkg::FRAMES];
  logic [lfu_pkg::COUNT_BITS-1:0] held_uses  [lfu_pkg::FRAMES];
  logic [lfu_pkg::FAULT_BITS-1:0] fault_tally;
  logic [lfu_pkg::FIU_BITS-1:0]   frames_cfg;

  lookup_result_t lookups_due [$];

  function automatic void flush_frames();
    for (int i = 0; i < lfu_pkg::FRAMES; i++) begin
      held_valid[i] = 1'b0;
      held_page[i]  = '0;
      held_uses[i]  = '0;
    end
    fault_tally = '0;
  endfunction

  function automatic lookup_result_t lookup_page(
      logic [lfu_pkg::PAGE_NUM_BITS-1:0] page_in, logic last);
    lookup_result_t                 res;
    logic [lfu_pkg::PAGE_BITS-1:0]  page;
    logic [lfu_pkg::COUNT_BITS-1:0] uses;
    logic [lfu_pkg::COUNT_BITS-1:0] fewest;
    logic                           found;
    int                             active;
    int                             slot;
    page   = page_in[lfu_pkg::PAGE_BITS-1:0];
    active = (frames_cfg == 0) ? 1 :
             (frames_cfg > lfu_pkg::FRAMES) ? lfu_pkg::FRAMES : int'(frames_cfg);
    found  = 1'b0;
    slot   = 0;
    fewest = '0;
    // empty frames count as zero uses; the first lowest count wins
    for (int i = 0; i < active; i++) begin
      uses = held_valid[i] ? held_uses[i] : '0;
      if (!found && held_valid[i] && held_page[i] == page) begin
        found = 1'b1;
        slot  = i;
      end
      if (i == 0 || uses < fewest) begin
        fewest = uses;
        if (!found) slot = i;
      end
    end
    if (found) begin
      if (held_uses[slot] != '1) held_uses[slot]++;
    end else begin
      if (fault_tally != '1) fault_tally++;
      held_valid[slot] = 1'b1;
      held_page[slot]  = page;
      held_uses[slot]  = lfu_pkg::COUNT_BITS'(1);
    end
    res.hit         = found;
    res.frame_index = slot[lfu_pkg::FRAME_IDX_BITS-1:0];
    res.fault_total = fault_tally;
    res.string_done = last;
    if (last) flush_frames();
    return res;
  endfunction

  function automatic void check_field(string name, logic [lfu_pkg::FAULT_BITS-1:0] want,
                                      logic [lfu_pkg::FAULT_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      flush_frames();
      frames_cfg = lfu_pkg::FIU_RESET;
      lookups_due.delete();
      errors  = 0;
      pending = 0;
    end else begin
      if (psel && penable && pready && paddr == FIU_ADDR) begin
        if (pwrite) frames_cfg = pwdata[lfu_pkg::FIU_BITS-1:0];
        else check_field("frames_in_use", lfu_pkg::FAULT_BITS'(frames_cfg),
                         lfu_pkg::FAULT_BITS'(prdata[lfu_pkg::FIU_BITS-1:0]));
      end
      if (in_mon.valid && in_mon.ready)
        lookups_due.push_back(lookup_page(in_mon.page_ref, in_mon.end_of_string));
      if (out_mon.valid && out_mon.ready) begin
        if (lookups_due.size() == 0) begin
          $error("result transaction with no page reference outstanding");
          errors++;
        end else begin
          want = lookups_due.pop_front();
          check_field("hit", lfu_pkg::FAULT_BITS'(want.hit),
                      lfu_pkg::FAULT_BITS'(out_mon.hit));
          check_field("frame_index", lfu_pkg::FAULT_BITS'(want.frame_index),
                      lfu_pkg::FAULT_BITS'(out_mon.frame_index));
          check_field("fault_total", want.fault_total, out_mon.fault_total);
          check_field("string_done", lfu_pkg::FAULT_BITS'(want.string_done),
                      lfu_pkg::FAULT_BITS'(out_mon.string_done));
        end
      end
      pending = lookups_due.size();
    end
  end

endmodule

// ----- bench/lfu_page_replacer_core_tb.sv -----
// top of the lfu page replacer bench: clock, reset, page reference and register stimulus
// depends on lfu_pkg, lfu_if, lfu_page_replacer_core and lfu_page_replacer_checker
module lfu_page_replacer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [lfu_pkg::PADDR_BITS-1:0] FIU_ADDR = {lfu_pkg::REG_FRAMES_IN_USE, 2'b00};
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PHASE_REFS    = 130;
  localparam int SAT_REFS      = 40;

  logic                           clk;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [lfu_pkg::PADDR_BITS-1:0] paddr;
  logic [lfu_pkg::PDATA_BITS-1:0] pwdata;
  logic [lfu_pkg::PDATA_BITS-1:0] prdata;
  logic                           pready;
  int                             errors;
  int                             pending;

  bit tx_gaps;
  bit rx_stall;
  int refs_sent;

  lfu_in_if  in_ch ();
  lfu_out_if out_ch ();

  lfu_page_replacer_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lfu_page_replacer_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side backpressure
  initial begin
    int unsigned hold;
    out_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      hold = rx_stall ? pick_gap() : 0;
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // valid stays high across back-to-back transactions
  task automatic send_ref(input logic [lfu_pkg::PAGE_NUM_BITS-1:0] page, input logic last);
    int unsigned idle;
    idle = tx_gaps ? pick_gap() : 0;
    if (idle != 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.page_ref      <= page;
    in_ch.end_of_string <= last;
    do @(posedge clk); while (!in_ch.ready);
    refs_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [lfu_pkg::FIU_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= FIU_ADDR;
    pwdata  <= ($urandom() & ~32'h1F) | lfu_pkg::PDATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_frames(input logic [lfu_pkg::FIU_BITS-1:0] value);
    wait_idle();
    apb_access(1'b1, value);
    @(posedge clk);
    apb_access(1'b0, '0);
  endtask

  // one reference string over a skewed working set, with some stray pages
  task automatic run_string(input int active);
    logic [lfu_pkg::PAGE_NUM_BITS-1:0] working [20];
    logic [lfu_pkg::PAGE_NUM_BITS-1:0] page;
    int                                set_size;
    int                                len;
    set_size = active + $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) set_size = $urandom_range(1, active);
    for (int i = 0; i < set_size; i++) working[i] = lfu_pkg::PAGE_NUM_BITS'($urandom());
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 60);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 85)
        page = working[$urandom_range(0, $urandom_range(0, set_size - 1))];
      else
        page = lfu_pkg::PAGE_NUM_BITS'($urandom());
      // a few strings run on without an end mark
      send_ref(page, k == len - 1 && $urandom_range(0, 9) != 0);
    end
  endtask

  initial begin
    logic [lfu_pkg::FIU_BITS-1:0] frame_settings [11];
    int                           active;
    int                           phase_end;
    int                           n;
    frame_settings = '{5'd1, 5'd0, 5'd2, 5'd31, 5'd17, 5'd5, 5'd16, 5'd9, 5'd3, 5'd8,
                       5'd12};
    frame_settings[10] = lfu_pkg::FIU_BITS'($urandom_range(0, 31));
    rst                 <= 1'b1;
    in_ch.valid         <= 1'b0;
    in_ch.page_ref      <= '0;
    in_ch.end_of_string <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    tx_gaps   = 1'b1;
    rx_stall  = 1'b1;
    refs_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setting of 16 frames: fill all, tie break, hits, end of string
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    for (int k = 1; k <= 14; k++) send_ref(16'h1111 * k, 1'b0);
    send_ref(16'hA5A5, 1'b0);
    send_ref(16'h2222, 1'b1);
    send_ref(16'h0000, 1'b0);
    send_ref(16'h5A5A, 1'b1);

    // a heavily used page must never look least used
    tx_gaps  = 1'b0;
    rx_stall = 1'b0;
    set_frames(5'd2);
    for (int k = 0; k < SAT_REFS; k++) send_ref(16'h3C3C, 1'b0);
    send_ref(16'hC3C3, 1'b0);
    send_ref(16'h9669, 1'b0);
    send_ref(16'h3C3C, 1'b1);

    foreach (frame_settings[p]) begin
      set_frames(frame_settings[p]);
      active = (frame_settings[p] == 0) ? 1 :
               (frame_settings[p] > lfu_pkg::FRAMES) ? lfu_pkg::FRAMES :
               int'(frame_settings[p]);
      tx_gaps   = $urandom_range(0, 3) != 0;
      rx_stall  = $urandom_range(0, 3) != 0;
      phase_end = refs_sent + PHASE_REFS;
      while (refs_sent < phase_end) begin
        run_string(active);
        if ($urandom_range(0, 9) == 0) wait_idle();
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    for (n = 0; n < DRAIN_LIMIT && pending != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/lfu_pkg.sv
hdl/lfu_if.sv
hdl/lfu_ram.sv
hdl/lfu_page_replacer_core.sv
hdl/lfu_chk.sv
bench/lfu_page_replacer_checker.sv
bench/lfu_page_replacer_core_tb.sv
